// File: rtl/elrd_pkg.sv
// Shared types, constants and the byte class map of the encoded line run detector.
// No dependencies; every other file of the block imports this package.
package elrd_pkg;

    localparam int LENGTH_BITS = 7;
    localparam int CFG_LEN_W   = 7;
    localparam int THRESH_W    = 4;
    localparam int RUN_W       = 4;
    localparam int CFG_IDX_W   = 3;

    typedef logic [LENGTH_BITS-1:0] line_len_t;
    typedef logic [RUN_W-1:0]       run_cnt_t;

    localparam line_len_t LEN_MAX = '1;
    localparam run_cnt_t  RUN_MAX = '1;

    // candidate mask bits
    localparam logic [2:0] T_UUE = 3'b001;
    localparam logic [2:0] T_B64 = 3'b010;
    localparam logic [2:0] T_BHX = 3'b100;

    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_QUOTE = 8'd62;
    localparam logic [7:0] BYTE_M     = 8'd77;

    // configuration reset values
    localparam logic [CFG_LEN_W-1:0] RST_UUE_LEN    = 7'd61;
    localparam logic [CFG_LEN_W-1:0] RST_B64_MIN    = 7'd60;
    localparam logic [CFG_LEN_W-1:0] RST_B64_MAX    = 7'd77;
    localparam logic [CFG_LEN_W-1:0] RST_BHX_MIN    = 7'd64;
    localparam logic [CFG_LEN_W-1:0] RST_BHX_MAX    = 7'd65;
    localparam logic [THRESH_W-1:0]  RST_RUN_THRESH = 4'd8;

    typedef enum logic [1:0] {
        POS_START  = 2'd0,
        POS_QUOTED = 2'd1,
        POS_FIRST  = 2'd2,
        POS_BODY   = 2'd3
    } line_pos_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_UUE  = 2'd1,
        KIND_BHX  = 2'd2,
        KIND_B64  = 2'd3
    } enc_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UUE_LEN    = 3'd0,
        REG_B64_MIN    = 3'd1,
        REG_B64_MAX    = 3'd2,
        REG_BHX_MIN    = 3'd3,
        REG_BHX_MAX    = 3'd4,
        REG_RUN_THRESH = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_LEN_W-1:0] uue_len;
        logic [CFG_LEN_W-1:0] b64_min;
        logic [CFG_LEN_W-1:0] b64_max;
        logic [CFG_LEN_W-1:0] bhx_min;
        logic [CFG_LEN_W-1:0] bhx_max;
        logic [THRESH_W-1:0]  run_thresh;
    } cfg_t;

    // line summary after the current byte has been scanned
    typedef struct packed {
        logic [2:0] maybe;
        logic [2:0] allowed;
        line_len_t  length;
        logic       first_is_m;
    } line_sum_t;

    typedef struct packed {
        run_cnt_t  uue_run;
        run_cnt_t  bhx_run;
        run_cnt_t  b64_run;
        enc_kind_t found_kind;
    } run_stat_t;

    // packed so that the candidate mask sits in the lowest bits
    typedef struct packed {
        enc_kind_t  kind;
        logic       found;
        run_cnt_t   run_length;
        enc_kind_t  line_class;
        logic [2:0] cand;
    } line_result_t;

    // 3-bit class of one byte: which encodings may contain it
    function automatic logic [2:0] byte_class(input logic [7:0] b);
        logic [2:0] c;
        c = 3'b000;
        if (b == BYTE_LF) begin
            c = T_UUE | T_B64 | T_BHX;
        end
        else begin
            if (b >= 8'd32 && b <= 8'd96)
                c = c | T_UUE;
            if (b == 8'd43 || (b >= 8'd47 && b <= 8'd57) || b == 8'd61 ||
                (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122))
                c = c | T_B64;
            if ((b >= 8'd33 && b <= 8'd45) ||
                (b >= 8'd48 && b <= 8'd57 && b != 8'd55) ||
                (b >= 8'd64 && b <= 8'd91 && b != 8'd79 && b != 8'd87) ||
                b == 8'd96 ||
                (b >= 8'd97 && b <= 8'd114 && b != 8'd103 && b != 8'd110 &&
                 b != 8'd111))
                c = c | T_BHX;
        end
        return c;
    endfunction

    function automatic line_len_t len_inc(input line_len_t l);
        return (l == LEN_MAX) ? LEN_MAX : l + line_len_t'(1);
    endfunction

    function automatic run_cnt_t run_bump(input run_cnt_t r);
        return (r == RUN_MAX) ? RUN_MAX : r + run_cnt_t'(1);
    endfunction

endpackage

// File: rtl/elrd_line_scan.sv
// Per-line scanner: quote skipping, CR hold-back, class masks and line length.
// Depends on elrd_pkg.
module elrd_line_scan
    import elrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic [7:0] data_byte,
    input  logic       end_of_line,
    input  logic       article_start,
    output line_sum_t  line_sum
);

    logic [2:0] maybe_reg, allowed_reg;
    line_len_t  length_reg;
    line_pos_t  pos_reg;
    logic       first_m_reg, held_cr_reg;

    logic [2:0] maybe_base, allowed_base;
    line_len_t  length_base;
    line_pos_t  pos_base;
    logic       first_m_base, held_cr_base;

    logic [2:0] maybe_next, allowed_next;
    line_len_t  length_next, length_mid;
    line_pos_t  pos_next;
    logic       first_m_next, held_cr_next;
    logic       scan_cr, scan_byte;
    logic [2:0] cls_byte, cls_cr;

    // a new message starts from a clean line
    always_comb
    begin
        if (article_start)
        begin
            maybe_base   = 3'b000;
            allowed_base = 3'b111;
            length_base  = '0;
            pos_base     = POS_START;
            first_m_base = 1'b0;
            held_cr_base = 1'b0;
        end
        else
        begin
            maybe_base   = maybe_reg;
            allowed_base = allowed_reg;
            length_base  = length_reg;
            pos_base     = pos_reg;
            first_m_base = first_m_reg;
            held_cr_base = held_cr_reg;
        end
    end

    always_comb
    begin
        pos_next     = pos_base;
        first_m_next = first_m_base;
        held_cr_next = held_cr_base;
        scan_cr      = 1'b0;
        scan_byte    = 1'b0;
        if (pos_base == POS_START && data_byte == BYTE_QUOTE)
        begin
            pos_next = POS_QUOTED;
        end
        else if (pos_base == POS_QUOTED && data_byte == BYTE_SPACE)
        begin
            pos_next = POS_FIRST;
        end
        else
        begin
            if (pos_base != POS_BODY)
            begin
                first_m_next = (data_byte == BYTE_M);
                pos_next     = POS_BODY;
            end
            if (end_of_line && data_byte == BYTE_LF)
            begin
                // drop the line ending, and any CR held before it
                held_cr_next = 1'b0;
            end
            else
            begin
                if (held_cr_base)
                begin
                    scan_cr      = 1'b1;
                    held_cr_next = 1'b0;
                end
                if (data_byte == BYTE_CR)
                begin
                    if (!end_of_line)
                        held_cr_next = 1'b1;
                end
                else
                begin
                    scan_byte = 1'b1;
                end
            end
        end
    end

    assign cls_byte = byte_class(data_byte);
    assign cls_cr   = byte_class(BYTE_CR);

    // a held CR is scanned ahead of the current byte
    always_comb
    begin
        maybe_next   = maybe_base | (scan_cr ? cls_cr : 3'b000)
                     | (scan_byte ? cls_byte : 3'b000);
        allowed_next = allowed_base & (scan_cr ? cls_cr : 3'b111)
                     & (scan_byte ? cls_byte : 3'b111);
        length_mid   = scan_cr ? len_inc(length_base) : length_base;
        length_next  = scan_byte ? len_inc(length_mid) : length_mid;
    end

    assign line_sum.maybe      = maybe_next;
    assign line_sum.allowed    = allowed_next;
    assign line_sum.length     = length_next;
    assign line_sum.first_is_m = first_m_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maybe_reg   <= 3'b000;
            allowed_reg <= 3'b111;
            length_reg  <= '0;
            pos_reg     <= POS_START;
            first_m_reg <= 1'b0;
            held_cr_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (end_of_line)
            begin
                maybe_reg   <= 3'b000;
                allowed_reg <= 3'b111;
                length_reg  <= '0;
                pos_reg     <= POS_START;
                first_m_reg <= 1'b0;
                held_cr_reg <= 1'b0;
            end
            else
            begin
                maybe_reg   <= maybe_next;
                allowed_reg <= allowed_next;
                length_reg  <= length_next;
                pos_reg     <= pos_next;
                first_m_reg <= first_m_next;
                held_cr_reg <= held_cr_next;
            end
        end
    end

endmodule

// File: rtl/elrd_run_track.sv
// Line classification, consecutive-run counters and the sticky binary verdict.
// Depends on elrd_pkg.
module elrd_run_track
    import elrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         end_of_line,
    input  logic         article_start,
    input  line_sum_t    line_sum,
    input  cfg_t         cfg,
    output line_result_t result,
    output run_stat_t    run_stat
);

    run_cnt_t  uue_run_reg, bhx_run_reg, b64_run_reg;
    enc_kind_t found_reg;

    run_cnt_t  uue_base, bhx_base, b64_base;
    enc_kind_t found_base;

    run_cnt_t   uue_next, bhx_next, b64_next, run_sel;
    enc_kind_t  found_next, cls;
    logic [2:0] lenok, cand;
    logic       frozen;

    assign uue_base   = article_start ? '0 : uue_run_reg;
    assign bhx_base   = article_start ? '0 : bhx_run_reg;
    assign b64_base   = article_start ? '0 : b64_run_reg;
    assign found_base = article_start ? KIND_NONE : found_reg;
    assign frozen     = (found_base != KIND_NONE);

    // length rules on the stripped line length
    always_comb
    begin
        lenok[0] = line_sum.first_is_m &&
                   (line_sum.length == LENGTH_BITS'(cfg.uue_len));
        lenok[1] = (line_sum.length >= LENGTH_BITS'(cfg.b64_min)) &&
                   (line_sum.length <= LENGTH_BITS'(cfg.b64_max));
        lenok[2] = (line_sum.length >= LENGTH_BITS'(cfg.bhx_min)) &&
                   (line_sum.length <= LENGTH_BITS'(cfg.bhx_max));
    end

    assign cand = line_sum.maybe & line_sum.allowed & lenok;

    always_comb
    begin
        uue_next = uue_base;
        bhx_next = bhx_base;
        b64_next = b64_base;
        cls      = KIND_NONE;
        run_sel  = '0;
        if ((cand & T_UUE) != 3'b000)
        begin
            cls = KIND_UUE;
            if (!frozen)
            begin
                uue_next = run_bump(uue_base);
                bhx_next = '0;
                b64_next = '0;
            end
            run_sel = uue_next;
        end
        else if ((cand & T_BHX) != 3'b000)
        begin
            cls = KIND_BHX;
            if (!frozen)
            begin
                bhx_next = run_bump(bhx_base);
                uue_next = '0;
                b64_next = '0;
            end
            run_sel = bhx_next;
        end
        else if ((cand & T_B64) != 3'b000)
        begin
            cls = KIND_B64;
            if (!frozen)
            begin
                b64_next = run_bump(b64_base);
                uue_next = '0;
                bhx_next = '0;
            end
            run_sel = b64_next;
        end
        else if (!frozen)
        begin
            uue_next = '0;
            bhx_next = '0;
            b64_next = '0;
        end
        found_next = found_base;
        if (!frozen && cls != KIND_NONE && run_sel > cfg.run_thresh)
            found_next = cls;
    end

    assign result.cand       = cand;
    assign result.line_class = cls;
    assign result.run_length = run_sel;
    assign result.found      = (found_next != KIND_NONE);
    assign result.kind       = found_next;

    assign run_stat.uue_run    = uue_run_reg;
    assign run_stat.bhx_run    = bhx_run_reg;
    assign run_stat.b64_run    = b64_run_reg;
    assign run_stat.found_kind = found_reg;

    // mid-line words only apply a pending message clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uue_run_reg <= '0;
            bhx_run_reg <= '0;
            b64_run_reg <= '0;
            found_reg   <= KIND_NONE;
        end
        else if (adv)
        begin
            if (end_of_line)
            begin
                uue_run_reg <= uue_next;
                bhx_run_reg <= bhx_next;
                b64_run_reg <= b64_next;
                found_reg   <= found_next;
            end
            else
            begin
                uue_run_reg <= uue_base;
                bhx_run_reg <= bhx_base;
                b64_run_reg <= b64_base;
                found_reg   <= found_base;
            end
        end
    end

endmodule

// File: rtl/encoded_line_run_detector.sv
// Top level of the encoded line run detector: ports, configuration registers,
// input and result registers. Depends on elrd_pkg, elrd_line_scan, elrd_run_track.

// The detector takes one message body byte per word and reports, for every
// word marked with tlast (the last byte of a line, line ending included), one
// result word classifying that line as uuencode, binhex, base64 or none, with
// the current run of consecutive lines of that class and a sticky verdict that
// is set once a run exceeds the run threshold. tuser on the input marks the
// first byte of a new message and clears runs and verdict before that byte.
// Words that do not end a line produce no result. Throughput is one word per
// clock: each byte needs one class-map lookup and a mask and length update,
// done between the input register and the result register. A line's result is
// loaded from the input register into the result register, which lets the next
// words keep flowing while a result waits for m_tready; only a line end that
// meets a full, stalled result register holds the input.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block itself
// does not enforce; indexes above five are ignored.
module encoded_line_run_detector
    import elrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_line
    input  logic                 s_tuser,   // article_start
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] candidate_mask, [4:3] line_class, [8:5] run_length,
    // [9] binary_found, [11:10] binary_kind, [15:12] zero
    output logic [15:0]          m_tdata,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_LEN_W-1:0] cfg_data
);

    cfg_t         cfg_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_eol_reg;
    logic         in_art_reg;
    logic         out_valid_reg;
    line_result_t out_res_reg;

    logic         adv;
    logic         out_free;
    line_sum_t    line_sum;
    line_result_t result;
    run_stat_t    run_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.uue_len    <= RST_UUE_LEN;
            cfg_reg.b64_min    <= RST_B64_MIN;
            cfg_reg.b64_max    <= RST_B64_MAX;
            cfg_reg.bhx_min    <= RST_BHX_MIN;
            cfg_reg.bhx_max    <= RST_BHX_MAX;
            cfg_reg.run_thresh <= RST_RUN_THRESH;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_UUE_LEN:    cfg_reg.uue_len    <= cfg_data;
                REG_B64_MIN:    cfg_reg.b64_min    <= cfg_data;
                REG_B64_MAX:    cfg_reg.b64_max    <= cfg_data;
                REG_BHX_MIN:    cfg_reg.bhx_min    <= cfg_data;
                REG_BHX_MAX:    cfg_reg.bhx_max    <= cfg_data;
                REG_RUN_THRESH: cfg_reg.run_thresh <= cfg_data[THRESH_W-1:0];
                default:        ; // ignore unused indexes
            endcase
        end
    end

    // advance the held word unless it ends a line and the result slot is busy
    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && (!in_eol_reg || out_free);
    assign s_tready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
            in_art_reg  <= s_tuser;
        end
    end

    elrd_line_scan u_line_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .data_byte     (in_byte_reg),
        .end_of_line   (in_eol_reg),
        .article_start (in_art_reg),
        .line_sum      (line_sum)
    );

    elrd_run_track u_run_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .end_of_line   (in_eol_reg),
        .article_start (in_art_reg),
        .line_sum      (line_sum),
        .cfg           (cfg_reg),
        .result        (result),
        .run_stat      (run_stat)
    );

    // result register: load at each line end, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && in_eol_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_eol_reg)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.kind, out_res_reg.found,
                       out_res_reg.run_length, out_res_reg.line_class,
                       out_res_reg.cand};

    // a held word that cannot advance stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input word lost or altered while stalled");

    // the verdict only changes through a message start
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_stat.found_kind != KIND_NONE && !(adv && in_art_reg))
        |=> (run_stat.found_kind == $past(run_stat.found_kind)))
        else $error("sticky verdict changed without a message start");

    // at most one run counter is live at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({run_stat.uue_run != '0, run_stat.bhx_run != '0,
                    run_stat.b64_run != '0}) <= 1)
        else $error("more than one run counter is non-zero");

    // a chosen uuencode class is always among the candidates of the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_eol_reg && result.line_class == KIND_UUE) |-> result.cand[0])
        else $error("uuencode chosen without uuencode candidate");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for encoded_line_run_detector: a directed table of line words, then
// random encoded-looking lines under several register settings, all checked word by word.
// Depends on elrd_pkg for port widths, enums and reset constants, and on the detector RTL.
module tb_top;
    import elrd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 135;
    // idle time before a register write, once the last result has left
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 5000;

    // indexes past the last register: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam line_result_t NO_TYPE  = '0;
    localparam logic [7:0]   BYTE_NUL = 8'h00;
    localparam logic [7:0]   BYTE_TOP = 8'hFF;

    typedef enum {LINE_UUE, LINE_BHX, LINE_B64, LINE_NOISE, LINE_BLANK, LINE_LONG} line_kind_e;
    typedef enum {END_BARE, END_LF, END_CRLF, END_CR} line_end_e;
    typedef enum {ROW_WORD, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [7:0]           data;
        logic                 eol;
        logic                 art;
        logic                 typed;   // expected result is NO_TYPE, written straight in
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_LEN_W-1:0] val;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;   // [7:0] data_byte
    logic                 s_tlast = 1'b0; // end_of_line
    logic                 s_tuser = 1'b0; // article_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [2:0] candidate_mask, [4:3] line_class, [8:5] run_length,
    // [9] binary_found, [11:10] binary_kind, [15:12] zero
    logic [15:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_LEN_W-1:0] cfg_data = '0;

    encoded_line_run_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor: own copy of the register file and the line state
    // ------------------------------------------------------------------
    logic [2:0]           enc_map [256];  // which encodings may hold each byte
    logic [CFG_LEN_W-1:0] uue_len_r, b64_min_r, b64_max_r, bhx_min_r, bhx_max_r;
    logic [THRESH_W-1:0]  thresh_r;
    logic [2:0]           seen_any, seen_all;
    line_len_t            scanned;
    line_pos_t            pos;
    logic                 lead_m, cr_held;
    run_cnt_t             uue_cnt, bhx_cnt, b64_cnt;
    enc_kind_t            verdict;

    line_result_t         expected_lines[$];

    int send_idle, recv_idle;
    logic hold_results = 1'b0;
    int words_sent, lines_checked, verdict_lines, bad_fields, settings_used, quiet;
    int class_tally[4];

    function automatic void restart_line();
        seen_any = 3'b000;
        seen_all = 3'b111;
        scanned  = '0;
        pos      = POS_START;
        lead_m   = 1'b0;
        cr_held  = 1'b0;
    endfunction

    function automatic void scan(input logic [7:0] b);
        seen_any = seen_any | enc_map[b];
        seen_all = seen_all & enc_map[b];
        if (scanned != LEN_MAX)
            scanned = scanned + 1'b1;
    endfunction

    function automatic run_cnt_t bump_run(input run_cnt_t r);
        return (r == RUN_MAX) ? r : r + 1'b1;
    endfunction

    // Advance the line state by one word; at a line end hand back the result word.
    function automatic void predict_line_result(input logic [7:0] b, input logic eol,
                                                input logic art, output line_result_t res);
        logic [2:0] fits;
        logic       frozen;
        res  = NO_TYPE;
        fits = 3'b000;
        if (art)
        begin
            restart_line();
            uue_cnt = '0;
            bhx_cnt = '0;
            b64_cnt = '0;
            verdict = KIND_NONE;
        end
        // skip a leading quote mark and one space after it
        if (pos == POS_START && b == BYTE_QUOTE)
            pos = POS_QUOTED;
        else if (pos == POS_QUOTED && b == BYTE_SPACE)
            pos = POS_FIRST;
        else
        begin
            if (pos != POS_BODY)
            begin
                lead_m = (b == BYTE_M);
                pos    = POS_BODY;
            end
            // a final LF is dropped with any CR held before it; a CR is held one word
            if (eol && b == BYTE_LF)
                cr_held = 1'b0;
            else
            begin
                if (cr_held)
                begin
                    scan(BYTE_CR);
                    cr_held = 1'b0;
                end
                if (b == BYTE_CR)
                    cr_held = !eol;
                else
                    scan(b);
            end
        end
        if (!eol)
            return;

        if (lead_m && scanned == uue_len_r)
            fits = fits | T_UUE;
        if (scanned >= b64_min_r && scanned <= b64_max_r)
            fits = fits | T_B64;
        if (scanned >= bhx_min_r && scanned <= bhx_max_r)
            fits = fits | T_BHX;
        res.cand = seen_any & seen_all & fits;

        // once the verdict is set the counters stay as they are until a new article
        frozen = (verdict != KIND_NONE);
        if ((res.cand & T_UUE) != 3'b000)
        begin
            res.line_class = KIND_UUE;
            if (!frozen)
            begin
                uue_cnt = bump_run(uue_cnt);
                bhx_cnt = '0;
                b64_cnt = '0;
            end
            res.run_length = uue_cnt;
        end
        else if ((res.cand & T_BHX) != 3'b000)
        begin
            res.line_class = KIND_BHX;
            if (!frozen)
            begin
                bhx_cnt = bump_run(bhx_cnt);
                uue_cnt = '0;
                b64_cnt = '0;
            end
            res.run_length = bhx_cnt;
        end
        else if ((res.cand & T_B64) != 3'b000)
        begin
            res.line_class = KIND_B64;
            if (!frozen)
            begin
                b64_cnt = bump_run(b64_cnt);
                uue_cnt = '0;
                bhx_cnt = '0;
            end
            res.run_length = b64_cnt;
        end
        else if (!frozen)
        begin
            uue_cnt = '0;
            bhx_cnt = '0;
            b64_cnt = '0;
        end
        if (!frozen && res.line_class != KIND_NONE && res.run_length > thresh_r)
            verdict = res.line_class;
        res.found = (verdict != KIND_NONE);
        res.kind  = verdict;
        restart_line();
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs change on the falling edge
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then log what the line end should report.
    task automatic send_word(input logic [7:0] b, input logic eol, input logic art,
                             input logic typed);
        line_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eol;
        s_tuser  = art;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        predict_line_result(b, eol, art, res);
        if (eol)
            expected_lines.push_back(typed ? NO_TYPE : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_LEN_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_UUE_LEN:    uue_len_r = val;
            REG_B64_MIN:    b64_min_r = val;
            REG_B64_MAX:    b64_max_r = val;
            REG_BHX_MIN:    bhx_min_r = val;
            REG_BHX_MAX:    bhx_max_r = val;
            REG_RUN_THRESH: thresh_r  = val[THRESH_W-1:0];
            default:        ;
        endcase
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Build one line: optional quote prefix, body of the chosen kind, optional line ending.
    task automatic send_line(input line_kind_e kind);
        logic [7:0] body[$];
        logic [7:0] b;
        int         n;
        int         pick;
        int         art_at;
        line_end_e  fin;
        case (kind)
            LINE_UUE:   n = uue_len_r;
            LINE_B64:   n = (b64_min_r > b64_max_r) ? b64_min_r
                                                     : $urandom_range(b64_max_r, b64_min_r);
            LINE_BHX:   n = (bhx_min_r > bhx_max_r) ? bhx_min_r
                                                     : $urandom_range(bhx_max_r, bhx_min_r);
            LINE_NOISE: n = $urandom_range(20);
            LINE_BLANK: n = 0;
            default:    n = $urandom_range(150, 120);
        endcase
        // nudge the length past the edges of the window now and then
        if ($urandom_range(99) < 15)
            n = n + int'($urandom_range(2)) - 1;
        if (n < 0)
            n = 0;
        if (n > 150)
            n = 150;

        pick = $urandom_range(99);
        if (pick < 12)
            body.push_back(BYTE_QUOTE);
        else if (pick < 24)
        begin
            body.push_back(BYTE_QUOTE);
            body.push_back(BYTE_SPACE);
        end
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                LINE_UUE:
                    b = (i == 0 && $urandom_range(99) < 85) ? BYTE_M
                                                           : 8'($urandom_range(96, 32));
                LINE_NOISE:
                    b = 8'($urandom_range(255));
                LINE_BHX:
                    do
                        b = 8'($urandom_range(122, 33));
                    while ((enc_map[b] & T_BHX) == 3'b000);
                default:
                    do
                        b = 8'($urandom_range(122, 33));
                    while ((enc_map[b] & T_B64) == 3'b000);
            endcase
            body.push_back(b);
        end

        fin = line_end_e'($urandom_range(3));
        if (body.size() == 0 && fin == END_BARE)
            fin = END_LF;
        case (fin)
            END_LF:   body.push_back(BYTE_LF);
            END_CRLF:
            begin
                body.push_back(BYTE_CR);
                body.push_back(BYTE_LF);
            end
            END_CR:   body.push_back(BYTE_CR);
            default:  ;
        endcase

        // new article mostly at a line start, sometimes in the middle of a noisy line
        art_at = -1;
        if ($urandom_range(99) < 4)
            art_at = 0;
        else if (kind == LINE_NOISE && $urandom_range(99) < 10)
            art_at = $urandom_range(body.size() - 1);
        foreach (body[i])
            send_word(body[i], i == body.size() - 1, i == art_at, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------
    always
    begin
        @(negedge clk);
        if (hold_results)
        begin
            hold_results = 1'b0;
            m_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clk);
        end
        m_tready = ($urandom_range(99) >= recv_idle);
    end

    // Compare each result word against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = line_result_t'(m_tdata[11:0]);
            lines_checked++;
            class_tally[got.line_class]++;
            if (got.found)
                verdict_lines++;
            if (expected_lines.size() == 0)
            begin
                $error("result word %h arrived with no line end outstanding", m_tdata);
                bad_fields++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (got.cand != want.cand)
                begin
                    $error("candidate_mask: expected %0d, got %0d", want.cand, got.cand);
                    bad_fields++;
                end
                if (got.line_class != want.line_class)
                begin
                    $error("line_class: expected %0d, got %0d", want.line_class, got.line_class);
                    bad_fields++;
                end
                if (got.run_length != want.run_length)
                begin
                    $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
                    bad_fields++;
                end
                if (got.found != want.found)
                begin
                    $error("binary_found: expected %0d, got %0d", want.found, got.found);
                    bad_fields++;
                end
                if (got.kind != want.kind)
                begin
                    $error("binary_kind: expected %0d, got %0d", want.kind, got.kind);
                    bad_fields++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no word moves on any port.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $error("no word moved for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t            plan[$];
        plan_row_t            row;
        line_kind_e           kind;
        logic                 prev_word;
        logic [CFG_LEN_W-1:0] v;
        int                   lo;
        int                   target;

        quiet = 0;
        words_sent = 0;
        lines_checked = 0;
        verdict_lines = 0;
        bad_fields = 0;
        settings_used = 1;
        foreach (class_tally[i])
            class_tally[i] = 0;

        for (int c = 0; c < 256; c++)
        begin
            enc_map[c] = 3'b000;
            if (c >= 32 && c <= 96)
                enc_map[c] = enc_map[c] | T_UUE;
            if (c == 43 || (c >= 47 && c <= 57) || c == 61 || (c >= 65 && c <= 90) ||
                (c >= 97 && c <= 122))
                enc_map[c] = enc_map[c] | T_B64;
            if ((c >= 33 && c <= 45) || (c >= 48 && c <= 57 && c != 55) ||
                (c >= 64 && c <= 91 && c != 79 && c != 87) || c == 96 ||
                (c >= 97 && c <= 114 && c != 103 && c != 110 && c != 111))
                enc_map[c] = enc_map[c] | T_BHX;
        end
        enc_map[BYTE_LF] = T_UUE | T_B64 | T_BHX;

        uue_len_r = RST_UUE_LEN;
        b64_min_r = RST_B64_MIN;
        b64_max_r = RST_B64_MAX;
        bhx_min_r = RST_BHX_MIN;
        bhx_max_r = RST_BHX_MAX;
        thresh_r  = RST_RUN_THRESH;
        restart_line();
        uue_cnt = '0;
        bhx_cnt = '0;
        b64_cnt = '0;
        verdict = KIND_NONE;

        // Directed table. Rows marked typed expect an all-zero result word:
        // with the reset lengths nothing this short can match any encoding.
        row = '{ROW_WORD, BYTE_LF, 1'b1, 1'b1, 1'b1, '0, '0};    plan.push_back(row); // empty line
        row = '{ROW_WORD, BYTE_QUOTE, 1'b1, 1'b0, 1'b1, '0, '0}; plan.push_back(row); // bare quote
        row = '{ROW_WORD, BYTE_QUOTE, 1'b0, 1'b0, 1'b0, '0, '0}; plan.push_back(row);
        row = '{ROW_WORD, BYTE_SPACE, 1'b1, 1'b0, 1'b1, '0, '0}; plan.push_back(row); // quote, space
        row = '{ROW_WORD, BYTE_TOP, 1'b1, 1'b0, 1'b1, '0, '0};   plan.push_back(row);
        row = '{ROW_WORD, BYTE_NUL, 1'b1, 1'b0, 1'b1, '0, '0};   plan.push_back(row);
        // short base64 window, inverted binhex limits, verdict on the first matching line
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_B64_MIN, 7'd2};    plan.push_back(row);
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_B64_MAX, 7'd4};    plan.push_back(row);
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_BHX_MIN, 7'd9};    plan.push_back(row);
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_BHX_MAX, 7'd2};    plan.push_back(row);
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_RUN_THRESH, 7'd0}; plan.push_back(row);
        // "MA" CR LF: the line ending is stripped, verdict set
        row = '{ROW_WORD, BYTE_M, 1'b0, 1'b0, 1'b0, '0, '0};     plan.push_back(row);
        row = '{ROW_WORD, 8'h41, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, BYTE_CR, 1'b0, 1'b0, 1'b0, '0, '0};    plan.push_back(row);
        row = '{ROW_WORD, BYTE_LF, 1'b1, 1'b0, 1'b0, '0, '0};    plan.push_back(row);
        // "zz+" after the verdict: counters frozen
        row = '{ROW_WORD, 8'h7A, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, 8'h7A, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, 8'h2B, 1'b1, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        // new article, quoted "qq" ended by a lone CR
        row = '{ROW_WORD, BYTE_QUOTE, 1'b0, 1'b1, 1'b0, '0, '0}; plan.push_back(row);
        row = '{ROW_WORD, BYTE_SPACE, 1'b0, 1'b0, 1'b0, '0, '0}; plan.push_back(row);
        row = '{ROW_WORD, 8'h71, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, 8'h71, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, BYTE_CR, 1'b1, 1'b0, 1'b0, '0, '0};    plan.push_back(row);
        // a CR inside the line is scanned and rules every encoding out
        row = '{ROW_WORD, 8'h61, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, BYTE_CR, 1'b0, 1'b0, 1'b0, '0, '0};    plan.push_back(row);
        row = '{ROW_WORD, 8'h62, 1'b1, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        // threshold at its top: the verdict can never be set
        row = '{ROW_REG, '0, 1'b0, 1'b0, 1'b0, REG_RUN_THRESH, 7'd15}; plan.push_back(row);
        row = '{ROW_WORD, BYTE_LF, 1'b0, 1'b1, 1'b0, '0, '0};    plan.push_back(row);
        row = '{ROW_WORD, 8'h41, 1'b0, 1'b0, 1'b0, '0, '0};      plan.push_back(row);
        row = '{ROW_WORD, 8'h42, 1'b1, 1'b0, 1'b0, '0, '0};      plan.push_back(row);

        send_idle = 23;
        recv_idle = 45;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        prev_word = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (prev_word)
                    settle();
                write_reg(plan[i].idx, plan[i].val);
                prev_word = 1'b0;
            end
            else
            begin
                send_word(plan[i].data, plan[i].eol, plan[i].art, plan[i].typed);
                prev_word = 1'b1;
            end
        end

        // Random lines: runs of one kind with the odd break, under a new setting per phase.
        kind = LINE_B64;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle = 23;
                recv_idle = 45;
            end
            else if (ph < 8)
            begin
                send_idle = 45;
                recv_idle = 23;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end

            if (ph != 0)
            begin
                settle();
                settings_used++;
                case (ph)
                    1:
                    begin
                        // lower extremes, widest base64 window
                        write_reg(REG_UUE_LEN, 7'd0);
                        write_reg(REG_B64_MIN, 7'd0);
                        write_reg(REG_B64_MAX, 7'd127);
                        write_reg(REG_BHX_MIN, 7'd0);
                        write_reg(REG_BHX_MAX, 7'd0);
                        write_reg(REG_RUN_THRESH, 7'd0);
                    end
                    2:
                    begin
                        // upper extremes: only saturated long lines can match
                        write_reg(REG_UUE_LEN, 7'd127);
                        write_reg(REG_B64_MIN, 7'd127);
                        write_reg(REG_B64_MAX, 7'd127);
                        write_reg(REG_BHX_MIN, 7'd127);
                        write_reg(REG_BHX_MAX, 7'd127);
                        write_reg(REG_RUN_THRESH, 7'd127);
                    end
                    3:
                    begin
                        // inverted windows; the spare indexes must not disturb anything
                        write_reg(REG_UUE_LEN, 7'd5);
                        write_reg(REG_B64_MIN, 7'd9);
                        write_reg(REG_B64_MAX, 7'd3);
                        write_reg(REG_BHX_MIN, 7'd12);
                        write_reg(REG_BHX_MAX, 7'd5);
                        write_reg(REG_RUN_THRESH, 7'd1);
                        write_reg(REG_SPARE_LO, 7'($urandom_range(127)));
                        write_reg(REG_SPARE_HI, 7'($urandom_range(127)));
                    end
                    default:
                    begin
                        write_reg(REG_UUE_LEN, 7'($urandom_range(14, 2)));
                        lo = $urandom_range(10, 1);
                        write_reg(REG_B64_MIN, 7'(lo));
                        write_reg(REG_B64_MAX, 7'(lo + int'($urandom_range(8))));
                        lo = $urandom_range(10, 1);
                        write_reg(REG_BHX_MIN, 7'(lo));
                        write_reg(REG_BHX_MAX, 7'(lo + int'($urandom_range(6))));
                        // threshold sits in the low bits; fill the rest with junk
                        v = 7'($urandom_range(127));
                        v[THRESH_W-1:0] = THRESH_W'($urandom_range(14, 1));
                        write_reg(REG_RUN_THRESH, v);
                        if ($urandom_range(1) == 1)
                            write_reg(REG_SPARE_HI, 7'($urandom_range(127)));
                    end
                endcase
            end

            // hold the result side off for a long stretch so the input backs up
            if (ph == 5)
                hold_results = 1'b1;

            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                if ($urandom_range(99) >= 75)
                begin
                    lo = $urandom_range(99);
                    if (lo < 27)
                        kind = LINE_UUE;
                    else if (lo < 50)
                        kind = LINE_BHX;
                    else if (lo < 75)
                        kind = LINE_B64;
                    else if (lo < 88)
                        kind = LINE_NOISE;
                    else if (lo < 97)
                        kind = LINE_BLANK;
                    else
                        kind = LINE_LONG;
                end
                send_line(kind);
                // never repeat a long line straight away
                if (kind == LINE_LONG)
                    kind = LINE_B64;
            end
        end

        settle();
        $display("Run covered %0d words, %0d line results over %0d register settings.",
                 words_sent, lines_checked, settings_used);
        $display("Lines by class: none %0d, uuencode %0d, binhex %0d, base64 %0d; %0d with verdict.",
                 class_tally[KIND_NONE], class_tally[KIND_UUE], class_tally[KIND_BHX],
                 class_tally[KIND_B64], verdict_lines);
        if (bad_fields == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
